>>> rtl/decimal_blink_code_signaller_defines.svh
// Assertion macros shared by the blink-code signaller RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef DECIMAL_BLINK_CODE_SIGNALLER_DEFINES_SVH
`define DECIMAL_BLINK_CODE_SIGNALLER_DEFINES_SVH

// Consequence must hold in the same cycle as the trigger.
`define DBC_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define DBC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> rtl/dbc_pkg.sv
// Types, codes and constants of the blink-code signaller.
// No dependencies; used by dbc_back and the top level of the block.
`timescale 1ns / 1ps

package dbc_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		REG_SLOT_BASE   = 2'd0,
		REG_CLOCK_SHIFT = 2'd1,
		REG_OFF_LEVEL   = 2'd2,
		REG_ON_LEVEL    = 2'd3
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC,
		ST_NEXT,
		ST_GAP,
		ST_DIGIT,
		ST_OFF,
		ST_LDONE,
		ST_TICK
	} st_t;

	typedef struct packed {
		logic        op;
		logic [15:0] value;
	} item_t;

	typedef struct packed {
		logic       led_level;
		logic       stepped;
		logic [7:0] passes_done;
	} res_t;

	typedef struct packed {
		logic [15:0] slot_base;
		logic [2:0]  clock_shift;
		logic        off_level;
		logic        on_level;
	} cfg_t;

	localparam logic [15:0] SLOT_BASE_RST = 16'd500;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
	localparam logic [7:0]  PASS_MAX      = 8'hFF;

	// sync preamble: slots 0..8, on for 3..5
	localparam logic [3:0] SYNC_LAST     = 4'd8;
	localparam logic [3:0] SYNC_ON_FIRST = 4'd3;
	localparam logic [3:0] SYNC_ON_LAST  = 4'd5;
	localparam logic [3:0] GAP_LAST      = 4'd2;
	localparam logic [2:0] DIG_LAST      = 3'd4;

	function automatic logic [15:0] digit_weight(input logic [2:0] idx);
		logic [15:0] w;
		case (idx)
			3'd0:    w = 16'd10000;
			3'd1:    w = 16'd1000;
			3'd2:    w = 16'd100;
			3'd3:    w = 16'd10;
			default: w = 16'd1;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/dbc_fifo.sv
// Small first-in first-out queue of fixed-width words.
// Stand-alone; used for the command and result queues.
`timescale 1ns / 1ps

module dbc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/dbc_back.sv
// Executes queued words: builds the slot pattern on a load, counts a tick and plays the next slot when one is due.
// Depends on dbc_pkg; holds the pattern memory.
`timescale 1ns / 1ps

module dbc_back #(
	parameter int PATTERN_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dbc_pkg::cfg_t       cfg,
	input  dbc_pkg::item_t      cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	output dbc_pkg::res_t       res,
	output logic                res_push,
	input  logic                res_full
);

	localparam int AW = $clog2(PATTERN_DEPTH);

	logic mem_q [PATTERN_DEPTH];
	logic rd_bit_q;

	dbc_pkg::st_t st_q, st_d;
	logic [7:0]   pos_q, pos_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [2:0]   dig_q, dig_d;
	logic         lead_q, lead_d;
	logic [15:0]  rest_q, rest_d;
	logic [7:0]   slot_cnt_q, slot_cnt_d;
	logic [7:0]   ptr_q, ptr_d;
	logic [7:0]   pass_q, pass_d;
	logic [15:0]  ticks_q, ticks_d;
	logic         armed_q, armed_d;
	logic         pin_q, pin_d;

	logic         wr_en, wr_bit;
	logic [15:0]  weight;
	logic [15:0]  te_inc, limit;
	logic         step, cur_bit, pin_new, wrap;
	logic [7:0]   ptr_inc, pass_inc;

	assign weight   = dbc_pkg::digit_weight(dig_q);
	assign te_inc   = (ticks_q == dbc_pkg::TICKS_MAX) ? ticks_q : ticks_q + 16'd1;
	assign limit    = cfg.slot_base >> cfg.clock_shift;
	assign step     = armed_q || (te_inc >= limit);
	// nothing loaded yet: slot 0 reads as off
	assign cur_bit  = (slot_cnt_q == 8'd0) ? 1'b0 : rd_bit_q;
	assign pin_new  = cur_bit ? cfg.on_level : cfg.off_level;
	assign ptr_inc  = ptr_q + 8'd1;
	assign wrap     = (ptr_inc >= slot_cnt_q);
	assign pass_inc = (pass_q == dbc_pkg::PASS_MAX) ? pass_q : pass_q + 8'd1;

	always_comb begin
		st_d       = st_q;
		pos_d      = pos_q;
		cnt_d      = cnt_q;
		dig_d      = dig_q;
		lead_d     = lead_q;
		rest_d     = rest_q;
		slot_cnt_d = slot_cnt_q;
		ptr_d      = ptr_q;
		pass_d     = pass_q;
		ticks_d    = ticks_q;
		armed_d    = armed_q;
		pin_d      = pin_q;
		wr_en      = 1'b0;
		wr_bit     = 1'b0;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res        = '{led_level: pin_q, stepped: 1'b0, passes_done: pass_q};
		unique case (st_q)
			dbc_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.op == dbc_pkg::OP_LOAD) begin
						rest_d  = cmd.value;
						pos_d   = 8'd0;
						cnt_d   = 4'd0;
						dig_d   = 3'd0;
						lead_d  = 1'b1;
						ptr_d   = 8'd0;
						pass_d  = 8'd0;
						ticks_d = 16'd0;
						armed_d = 1'b1;
						st_d    = dbc_pkg::ST_SYNC;
					end else begin
						st_d = dbc_pkg::ST_TICK;
					end
				end
			end
			dbc_pkg::ST_SYNC: begin
				wr_en  = 1'b1;
				wr_bit = (cnt_q >= dbc_pkg::SYNC_ON_FIRST) && (cnt_q <= dbc_pkg::SYNC_ON_LAST);
				pos_d  = pos_q + 8'd1;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == dbc_pkg::SYNC_LAST) begin
					st_d = dbc_pkg::ST_NEXT;
				end
			end
			dbc_pkg::ST_NEXT: begin
				cnt_d = 4'd0;
				st_d  = lead_q ? dbc_pkg::ST_DIGIT : dbc_pkg::ST_GAP;
			end
			dbc_pkg::ST_GAP: begin
				wr_en = 1'b1;
				pos_d = pos_q + 8'd1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == dbc_pkg::GAP_LAST) begin
					st_d = dbc_pkg::ST_DIGIT;
				end
			end
			dbc_pkg::ST_DIGIT: begin
				// one on/off pair per weight that still fits in the remainder
				if (rest_q >= weight) begin
					wr_en  = 1'b1;
					wr_bit = 1'b1;
					pos_d  = pos_q + 8'd1;
					rest_d = rest_q - weight;
					lead_d = 1'b0;
					st_d   = dbc_pkg::ST_OFF;
				end else if (dig_q == dbc_pkg::DIG_LAST) begin
					st_d = dbc_pkg::ST_LDONE;
				end else begin
					dig_d = dig_q + 3'd1;
					st_d  = dbc_pkg::ST_NEXT;
				end
			end
			dbc_pkg::ST_OFF: begin
				wr_en = 1'b1;
				pos_d = pos_q + 8'd1;
				st_d  = dbc_pkg::ST_DIGIT;
			end
			dbc_pkg::ST_LDONE: begin
				slot_cnt_d = pos_q;
				if (!res_full) begin
					res_push = 1'b1;
					st_d     = dbc_pkg::ST_IDLE;
				end
			end
			dbc_pkg::ST_TICK: begin
				if (!res_full) begin
					res_push = 1'b1;
					st_d     = dbc_pkg::ST_IDLE;
					if (step) begin
						pin_d   = pin_new;
						ptr_d   = wrap ? 8'd0 : ptr_inc;
						pass_d  = wrap ? pass_inc : pass_q;
						ticks_d = 16'd0;
						armed_d = 1'b0;
					end else begin
						ticks_d = te_inc;
					end
					res = '{led_level: pin_d, stepped: step, passes_done: pass_d};
				end
			end
			default: begin
				st_d = dbc_pkg::ST_IDLE;
			end
		endcase
	end

	// pattern memory: one write port from the builder, registered read at the play pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[pos_q[AW-1:0]] <= wr_bit;
		end
		rd_bit_q <= mem_q[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= dbc_pkg::ST_IDLE;
			pos_q      <= '0;
			cnt_q      <= '0;
			dig_q      <= '0;
			lead_q     <= 1'b1;
			rest_q     <= '0;
			slot_cnt_q <= '0;
			ptr_q      <= '0;
			pass_q     <= '0;
			ticks_q    <= '0;
			armed_q    <= 1'b1;
			pin_q      <= 1'b0;
		end else begin
			st_q       <= st_d;
			pos_q      <= pos_d;
			cnt_q      <= cnt_d;
			dig_q      <= dig_d;
			lead_q     <= lead_d;
			rest_q     <= rest_d;
			slot_cnt_q <= slot_cnt_d;
			ptr_q      <= ptr_d;
			pass_q     <= pass_d;
			ticks_q    <= ticks_d;
			armed_q    <= armed_d;
			pin_q      <= pin_d;
		end
	end

endmodule

>>> rtl/decimal_blink_code_signaller.sv
// Top level of the decimal blink-code signaller: configuration registers and queues.
// Depends on dbc_pkg, dbc_fifo, dbc_back and decimal_blink_code_signaller_defines.svh.
`timescale 1ns / 1ps
`include "decimal_blink_code_signaller_defines.svh"

// Usage:
// Words enter through push/full (op, value) into a two-word command queue.
// op = tick advances the slot timer and plays the next slot when one is due;
// op = load rebuilds the slot pattern for value.
// Each word yields one result word (led_level, stepped, passes_done) in a two-word result
// queue, read through empty/pop; the oldest word is on the ports while empty is low.
// The executor takes one word at a time and pops the next word only after it has
// pushed the result of the last. A tick passes through the idle and tick states; a
// load writes the slots one at a time through the single write port of the pattern
// memory, from the sync state through the gap, digit and off states to the done state.
// When the result queue is full the executor holds its word, and the command
// queue fills behind it until full rises; nothing is dropped.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// must be written only while the block is idle.
// Reset empties both queues, restores the register defaults, clears the
// pattern length and pass count, arms the first step and sets the held pin level low.
// No memory clearing pass runs after reset.

module decimal_blink_code_signaller #(
	parameter int PATTERN_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [15:0] value,
	output logic        empty,
	input  logic        pop,
	output logic        led_level,
	output logic        stepped,
	output logic [7:0]  passes_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dbc_pkg::cfg_t  cfg_q;
	dbc_pkg::item_t in_word, cmd;
	dbc_pkg::res_t  res_word, res_out;
	logic           in_empty, in_pop;
	logic           res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_base   <= dbc_pkg::SLOT_BASE_RST;
			cfg_q.clock_shift <= 3'd0;
			cfg_q.off_level   <= 1'b0;
			cfg_q.on_level    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dbc_pkg::cfg_reg_e'(cfg_index))
				dbc_pkg::REG_SLOT_BASE:   cfg_q.slot_base   <= cfg_data;
				dbc_pkg::REG_CLOCK_SHIFT: cfg_q.clock_shift <= cfg_data[2:0];
				dbc_pkg::REG_OFF_LEVEL:   cfg_q.off_level   <= cfg_data[0];
				dbc_pkg::REG_ON_LEVEL:    cfg_q.on_level    <= cfg_data[0];
			endcase
		end
	end

	assign in_word = '{op: op, value: value};

	dbc_fifo #(
		.WIDTH($bits(dbc_pkg::item_t)),
		.DEPTH(dbc_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_word),
		.full  (full),
		.pop   (in_pop),
		.rdata (cmd),
		.empty (in_empty)
	);

	dbc_back #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.cmd_empty(in_empty),
		.cmd_pop  (in_pop),
		.res      (res_word),
		.res_push (res_push),
		.res_full (res_full)
	);

	dbc_fifo #(
		.WIDTH($bits(dbc_pkg::res_t)),
		.DEPTH(dbc_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_word),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign led_level   = res_out.led_level;
	assign stepped     = res_out.stepped;
	assign passes_done = res_out.passes_done;

	`DBC_ASSERT_SAME(a_cmd_pop_nonempty, in_pop, !in_empty, "command pop from empty queue")
	`DBC_ASSERT_SAME(a_res_push_space, res_push, !res_full, "result push into full queue")
	`DBC_ASSERT_NEXT(a_one_word_at_a_time, in_pop, !in_pop, "executor took two words back to back")

endmodule
